// ----- design/kwm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared widths, codes and defaults of the prioritized keyword marker.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int NUM_PATTERNS_DEF    = 16;
	localparam int MAX_PATTERN_LEN_DEF = 16;

	localparam int MODE_W  = 2;
	localparam int INDEX_W = 4;
	localparam int POS_W   = 4;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 5;
	localparam int COUNT_W = 5;

	localparam logic [MODE_W-1:0] MODE_PAT_BYTE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PAT_LEN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TEXT     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE     = 2'd3;

	localparam logic [BYTE_W-1:0] MARK_BYTE = 8'h2A;

endpackage

// ----- design/kwm_in_if.sv -----
// ----------------------------------------------------------------------------
// kwm_in_if
// Input item channel: pattern writes, length writes and text bytes.
// ----------------------------------------------------------------------------
interface kwm_in_if;
	import kwm_pkg::*;

	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [INDEX_W-1:0] pattern_index;
	logic [POS_W-1:0]   char_position;
	logic [BYTE_W-1:0]  byte_value;
	logic [LEN_W-1:0]   pattern_length;
	logic               end_of_text;

	modport source (output valid, mode, pattern_index, char_position, byte_value,
		pattern_length, end_of_text, input ready);
	modport sink (input valid, mode, pattern_index, char_position, byte_value,
		pattern_length, end_of_text, output ready);
endinterface

// ----- design/kwm_out_if.sv -----
// ----------------------------------------------------------------------------
// kwm_out_if
// Result channel: one output byte per transfer with its end markers.
// ----------------------------------------------------------------------------
interface kwm_out_if;
	import kwm_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              run_last;
	logic              text_done;

	modport source (output valid, out_byte, run_last, text_done, input ready);
	modport sink (input valid, out_byte, run_last, text_done, output ready);
endinterface

// ----- design/kwm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// kwm_cfg_if
// Configuration write channel carrying the pattern count.
// ----------------------------------------------------------------------------
interface kwm_cfg_if;
	import kwm_pkg::*;

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] pattern_count;

	modport source (output valid, pattern_count, input ready);
	modport sink (input valid, pattern_count, output ready);
endinterface

// ----- design/prioritized_keyword_marker_core.sv -----
// ----------------------------------------------------------------------------
// prioritized_keyword_marker_core
// Greedy multi-pattern marker: text bytes are matched against stored
// keywords in priority order, and matches are wrapped in asterisks.
// ----------------------------------------------------------------------------
//
//  channel   | dir | payload                                        | transfer
//  ----------+-----+------------------------------------------------+----------------
//  text_in   | in  | mode, pattern_index, char_position, byte_value,| valid && ready
//            |     | pattern_length, end_of_text                    |
//  text_out  | out | out_byte, run_last, text_done                  | valid && ready
//  cfg       | in  | pattern_count                                  | valid (ready=1)
//
// Pattern byte and length writes leave the block ready.
// A text byte enters the window (a full window is flushed first); the
// sequencer then runs decisions over one shared byte comparator until
// the window empties or holds back a prefix: S_START, S_PAT per pattern
// tried, S_RD (memory read) then S_CMP (compare) per compared byte,
// S_EMIT per result byte, and S_SINGLE when no pattern matches. The
// item ends in S_FINAL.
// Reset clears the lengths, the count and the window fill; the pattern
// memory has no reset and is read only below a written length.
// A stalled result channel holds the sequencer; text_in is ready only
// while the block is idle.
// ----------------------------------------------------------------------------
module prioritized_keyword_marker_core #(
	parameter int NUM_PATTERNS    = kwm_pkg::NUM_PATTERNS_DEF,
	parameter int MAX_PATTERN_LEN = kwm_pkg::MAX_PATTERN_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	kwm_in_if.sink    text_in,
	kwm_out_if.source text_out,
	kwm_cfg_if.sink   cfg
);
	import kwm_pkg::*;

	localparam int NP  = NUM_PATTERNS;
	localparam int ML  = MAX_PATTERN_LEN;
	localparam int IW  = (NP > 1) ? $clog2(NP) : 1;
	localparam int KW  = $clog2(NP + 1);
	localparam int PW  = (ML > 1) ? $clog2(ML) : 1;
	localparam int FW  = $clog2(ML + 1);
	localparam int EW  = $clog2(ML + 2);
	localparam int AW  = (NP * ML > 1) ? $clog2(NP * ML) : 1;
	localparam int CAP = 3 * ML;
	localparam int CW  = $clog2(CAP + 1);

	// Sequencer states.
	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_APPEND = 9'b000000010,
		S_START  = 9'b000000100,
		S_PAT    = 9'b000001000,
		S_RD     = 9'b000010000,
		S_CMP    = 9'b000100000,
		S_EMIT   = 9'b001000000,
		S_SINGLE = 9'b010000000,
		S_FINAL  = 9'b100000000
	} state_t;

	// Wraps a sum below twice the window depth back into the window.
	function automatic logic [PW-1:0] wrap_idx(input logic [FW:0] s);
		logic [FW:0] r;
		r = (s >= (FW+1)'(ML)) ? s - (FW+1)'(ML) : s;
		return r[PW-1:0];
	endfunction

	state_t              state_q;
	logic [COUNT_W-1:0]  count_q;
	logic [FW-1:0]       lengths_q [NP];
	logic [7:0]          window_q [ML];
	logic [PW-1:0]       head_q;
	logic [FW-1:0]       fill_q;
	logic [KW-1:0]       k_q;
	logic [AW-1:0]       base_q;
	logic [FW-1:0]       len_q;
	logic [FW-1:0]       j_q;
	logic [EW-1:0]       e_q;
	logic [CW-1:0]       cnt_q;
	logic                pre_q;
	logic                flush_q;
	logic                eot_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [BYTE_W-1:0]   hold_q;
	logic                hold_v_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                out_v_q;
	logic                last_q;
	logic                done_q;
	logic [7:0]          rd_data_q;

	// Pattern store: one write port from the input, one read port for
	// the comparator.
	logic [7:0] store_mem [NP * ML];

	logic          in_take;
	logic          out_take;
	logic          store_we;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [KW-1:0] used;
	logic [FW-1:0] len_k;
	logic [FW-1:0] m_len;
	logic [PW-1:0] win_idx;
	logic [7:0]    win_rd;
	logic [7:0]    push_byte;
	logic          emitting;
	logic          push_ok;
	logic          push_real;
	logic          final_ok;
	logic [FW-1:0] len_clamp;

	assign in_take  = text_in.valid && text_in.ready;
	assign out_take = text_out.valid && text_out.ready;
	assign text_in.ready = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;

	assign text_out.valid     = out_v_q;
	assign text_out.out_byte  = out_byte_q;
	assign text_out.run_last  = last_q;
	assign text_out.text_done = done_q;

	assign store_we = in_take && (text_in.mode == MODE_PAT_BYTE)
		&& (7'(text_in.pattern_index) < 7'(NP)) && (7'(text_in.char_position) < 7'(ML));
	assign wr_addr = AW'(32'(text_in.pattern_index) * ML + 32'(text_in.char_position));
	assign rd_addr = base_q + AW'(j_q);

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[wr_addr] <= text_in.byte_value;
		end
		rd_data_q <= store_mem[rd_addr];
	end

	assign used  = (7'(count_q) > 7'(NP)) ? KW'(NP) : KW'(count_q);
	assign len_k = lengths_q[k_q[IW-1:0]];
	assign m_len = (len_q < fill_q) ? len_q : fill_q;
	assign len_clamp = (7'(text_in.pattern_length) > 7'(ML)) ? FW'(ML)
		: FW'(text_in.pattern_length);

	// Window read address: compare offset, emit offset or the front byte.
	always_comb begin
		win_idx = head_q;
		unique case (state_q)
			S_CMP:   win_idx = wrap_idx((FW+1)'(head_q) + (FW+1)'(j_q));
			S_EMIT:  win_idx = wrap_idx((FW+1)'(head_q) + (FW+1)'(e_q) - (FW+1)'(1));
			default: win_idx = head_q;
		endcase
	end
	assign win_rd = window_q[win_idx];

	assign push_byte = ((state_q == S_EMIT) && ((e_q == '0) || (e_q == EW'(len_q) + EW'(1))))
		? MARK_BYTE : win_rd;
	assign emitting  = (state_q == S_EMIT) || (state_q == S_SINGLE);
	// Bytes beyond the per-item cap are dropped without waiting.
	assign push_ok   = (cnt_q >= CW'(CAP)) || !(hold_v_q && out_v_q && !text_out.ready);
	assign push_real = emitting && push_ok && (cnt_q < CW'(CAP));
	assign final_ok  = (state_q == S_FINAL) && (!hold_v_q || !out_v_q || text_out.ready);

	always_ff @(posedge clk) begin
		if (state_q == S_APPEND) begin
			window_q[wrap_idx((FW+1)'(head_q) + (FW+1)'(fill_q))] <= byte_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			lengths_q  <= '{default: '0};
			head_q     <= '0;
			fill_q     <= '0;
			k_q        <= '0;
			base_q     <= '0;
			len_q      <= '0;
			j_q        <= '0;
			e_q        <= '0;
			cnt_q      <= '0;
			pre_q      <= 1'b0;
			flush_q    <= 1'b0;
			eot_q      <= 1'b0;
			byte_q     <= '0;
			hold_q     <= '0;
			hold_v_q   <= 1'b0;
			out_byte_q <= '0;
			out_v_q    <= 1'b0;
			last_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				count_q <= cfg.pattern_count;
			end
			// The output register empties unless the held byte moves in.
			if (out_take && !(hold_v_q && (push_real || final_ok))) begin
				out_v_q <= 1'b0;
			end
			// The held byte moves out once a newer byte proves it is not last.
			if (push_real) begin
				if (hold_v_q) begin
					out_byte_q <= hold_q;
					last_q     <= 1'b0;
					done_q     <= 1'b0;
					out_v_q    <= 1'b1;
				end
				hold_q   <= push_byte;
				hold_v_q <= 1'b1;
				cnt_q    <= cnt_q + CW'(1);
			end
			if (final_ok && hold_v_q) begin
				out_byte_q <= hold_q;
				last_q     <= 1'b1;
				done_q     <= eot_q;
				out_v_q    <= 1'b1;
				hold_v_q   <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (text_in.mode == MODE_PAT_LEN) begin
							if (7'(text_in.pattern_index) < 7'(NP)) begin
								lengths_q[text_in.pattern_index[IW-1:0]] <= len_clamp;
							end
						end else if (text_in.mode == MODE_TEXT) begin
							byte_q <= text_in.byte_value;
							eot_q  <= text_in.end_of_text;
							cnt_q  <= '0;
							// A full window is flushed before the new byte enters.
							if (fill_q >= FW'(ML)) begin
								pre_q   <= 1'b1;
								flush_q <= 1'b1;
								state_q <= S_START;
							end else begin
								flush_q <= text_in.end_of_text;
								state_q <= S_APPEND;
							end
						end
					end
				end
				S_APPEND: begin
					fill_q  <= fill_q + FW'(1);
					state_q <= S_START;
				end
				S_START: begin
					if (fill_q == '0) begin
						if (pre_q) begin
							pre_q   <= 1'b0;
							flush_q <= eot_q;
							state_q <= S_APPEND;
						end else begin
							state_q <= S_FINAL;
						end
					end else begin
						k_q     <= '0;
						base_q  <= '0;
						state_q <= S_PAT;
					end
				end
				S_PAT: begin
					if (k_q >= used) begin
						state_q <= S_SINGLE;
					end else if (len_k == '0) begin
						k_q    <= k_q + KW'(1);
						base_q <= base_q + AW'(ML);
					end else begin
						len_q   <= len_k;
						j_q     <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (rd_data_q != win_rd) begin
						k_q     <= k_q + KW'(1);
						base_q  <= base_q + AW'(ML);
						state_q <= S_PAT;
					end else if (j_q + FW'(1) == m_len) begin
						if (len_q <= fill_q) begin
							e_q     <= '0;
							state_q <= S_EMIT;
						end else if (!flush_q) begin
							// Window is a proper prefix: hold bytes back.
							state_q <= S_FINAL;
						end else begin
							k_q     <= k_q + KW'(1);
							base_q  <= base_q + AW'(ML);
							state_q <= S_PAT;
						end
					end else begin
						j_q     <= j_q + FW'(1);
						state_q <= S_RD;
					end
				end
				S_EMIT: begin
					if (push_ok) begin
						if (e_q == EW'(len_q) + EW'(1)) begin
							head_q  <= wrap_idx((FW+1)'(head_q) + (FW+1)'(len_q));
							fill_q  <= fill_q - len_q;
							state_q <= S_START;
						end else begin
							e_q <= e_q + EW'(1);
						end
					end
				end
				S_SINGLE: begin
					if (push_ok) begin
						head_q  <= wrap_idx((FW+1)'(head_q) + (FW+1)'(1));
						fill_q  <= fill_q - FW'(1);
						state_q <= S_START;
					end
				end
				S_FINAL: begin
					if (final_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A finished text always ends on the last byte of its item.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		text_out.valid && text_out.text_done |-> text_out.run_last)
		else $error("text_done without run_last");

	// No byte may be held over while the block waits for a new item.
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		text_in.ready |-> !hold_v_q)
		else $error("held result byte while idle");

	// The window never holds more than its depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(ML))
		else $error("window fill beyond depth");

	// Results per item stay within the cap.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAP))
		else $error("result count beyond cap");

endmodule
